@@ design/gbts_pkg.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Shared constants, request classes and the queued request type.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = 11;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_W-1:0] OP_BACKSPACE    = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE         = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE_RANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ         = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD_POS = 2'd2;

  typedef enum logic [2:0] {
    KIND_INSERT,
    KIND_BACKSPACE,
    KIND_MOVE,
    KIND_DELETE,
    KIND_READ,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  end_position;
  } req_t;

endpackage

@@ design/gbts_front.sv @@
// ----------------------------------------------------------------------------
// Gap buffer front end
// Accepts requests and classifies the operation code for the back end.
// ----------------------------------------------------------------------------
module gbts_front (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gbts_pkg::OP_W-1:0]    operation_i,
  input  logic [gbts_pkg::CHAR_W-1:0]  char_in_i,
  input  logic [gbts_pkg::POS_W-1:0]   position_i,
  input  logic [gbts_pkg::POS_W-1:0]   end_position_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output gbts_pkg::req_t               push_req_o
);

  gbts_pkg::kind_e kind;

  always_comb begin
    unique case (operation_i)
      gbts_pkg::OP_INSERT:       kind = gbts_pkg::KIND_INSERT;
      gbts_pkg::OP_BACKSPACE:    kind = gbts_pkg::KIND_BACKSPACE;
      gbts_pkg::OP_MOVE:         kind = gbts_pkg::KIND_MOVE;
      gbts_pkg::OP_DELETE_RANGE: kind = gbts_pkg::KIND_DELETE;
      gbts_pkg::OP_READ:         kind = gbts_pkg::KIND_READ;
      default:                   kind = gbts_pkg::KIND_NOP;
    endcase
  end

  assign push_valid_o             = in_valid_i;
  assign in_ready_o               = push_ready_i;
  assign push_req_o.kind          = kind;
  assign push_req_o.char_in       = char_in_i;
  assign push_req_o.position      = position_i;
  assign push_req_o.end_position  = end_position_i;

endmodule

@@ design/gbts_queue.sv @@
// ----------------------------------------------------------------------------
// Gap buffer request queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module gbts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  gbts_pkg::req_t push_req_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output gbts_pkg::req_t pop_req_o
);

  gbts_pkg::req_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_req_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

@@ design/gbts_back.sv @@
// ----------------------------------------------------------------------------
// Gap buffer back end
// Executes requests on the text memory and the gap pointers, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module gbts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  gbts_pkg::req_t                pop_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gbts_pkg::STAT_W-1:0]   status_o,
  output logic [gbts_pkg::POS_W-1:0]    cursor_o,
  output logic [gbts_pkg::POS_W-1:0]    text_length_o,
  output logic [gbts_pkg::CHAR_W-1:0]   char_out_o
);

  localparam int unsigned POS_W  = gbts_pkg::POS_W;
  localparam int unsigned ADDR_W = gbts_pkg::ADDR_W;
  localparam int unsigned CHAR_W = gbts_pkg::CHAR_W;
  localparam logic [POS_W-1:0] CAP_POS = POS_W'(gbts_pkg::CAPACITY);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_MOVE   = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  gbts_pkg::req_t               req_q, req_d;
  logic [POS_W-1:0]             gb_q, gb_d;
  logic [POS_W-1:0]             gf_q, gf_d;
  logic [POS_W-1:0]             tgt_q, tgt_d;
  logic [POS_W-1:0]             span_q, span_d;
  logic [ADDR_W-1:0]            wa_q, wa_d;
  logic                         pend_q, pend_d;
  logic                         char_sel_q, char_sel_d;
  logic [gbts_pkg::STAT_W-1:0]  stat_q, stat_d;
  logic                         out_valid_q, out_valid_d;
  logic                         load;
  logic [gbts_pkg::STAT_W-1:0]  out_status_q;
  logic [POS_W-1:0]             out_cursor_q;
  logic [POS_W-1:0]             out_len_q;
  logic [CHAR_W-1:0]            out_char_q;

  logic [CHAR_W-1:0]            mem_q [gbts_pkg::CAPACITY];
  logic [CHAR_W-1:0]            rd_data_q;
  logic                         mem_we, mem_re;
  logic [ADDR_W-1:0]            mem_wa, mem_ra;
  logic [CHAR_W-1:0]            mem_wd;

  logic [POS_W-1:0]             len;
  logic [POS_W-1:0]             phys;

  assign len  = CAP_POS - (gf_q - gb_q);
  assign phys = (req_q.position < gb_q) ? req_q.position
                                        : req_q.position + (gf_q - gb_q);

  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    gb_d       = gb_q;
    gf_d       = gf_q;
    tgt_d      = tgt_q;
    span_d     = span_q;
    wa_d       = wa_q;
    pend_d     = 1'b0;
    char_sel_d = char_sel_q;
    stat_d     = stat_q;
    pop_o      = 1'b0;
    load       = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = wa_q;
    mem_wd     = rd_data_q;
    mem_re     = 1'b0;
    mem_ra     = phys[ADDR_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          req_d   = pop_req_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        stat_d     = gbts_pkg::STATUS_DONE;
        char_sel_d = 1'b0;
        span_d     = '0;
        tgt_d      = req_q.position;
        state_d    = ST_FINISH;
        case (req_q.kind)
          gbts_pkg::KIND_INSERT: begin
            if (gb_q == gf_q) begin
              stat_d = gbts_pkg::STATUS_FULL;
            end else begin
              mem_we = 1'b1;
              mem_wa = gb_q[ADDR_W-1:0];
              mem_wd = req_q.char_in;
              gb_d   = gb_q + POS_W'(1);
            end
          end
          gbts_pkg::KIND_BACKSPACE: begin
            if (gb_q != '0) begin
              gb_d = gb_q - POS_W'(1);
            end
          end
          gbts_pkg::KIND_MOVE: begin
            if (req_q.position > len) begin
              stat_d = gbts_pkg::STATUS_BAD_POS;
            end else begin
              state_d = ST_MOVE;
            end
          end
          gbts_pkg::KIND_DELETE: begin
            if (req_q.position < req_q.end_position) begin
              if (req_q.end_position > len) begin
                stat_d = gbts_pkg::STATUS_BAD_POS;
              end else begin
                span_d  = req_q.end_position - req_q.position;
                state_d = ST_MOVE;
              end
            end
          end
          gbts_pkg::KIND_READ: begin
            if (req_q.position >= len) begin
              stat_d = gbts_pkg::STATUS_BAD_POS;
            end else begin
              mem_re     = 1'b1;
              char_sel_d = 1'b1;
              state_d    = ST_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      ST_MOVE: begin
        // The byte read in the previous cycle lands at its destination now.
        mem_we = pend_q;
        if (gb_q > tgt_q) begin
          mem_re = 1'b1;
          mem_ra = ADDR_W'(gb_q - POS_W'(1));
          wa_d   = ADDR_W'(gf_q - POS_W'(1));
          gb_d   = gb_q - POS_W'(1);
          gf_d   = gf_q - POS_W'(1);
          pend_d = 1'b1;
        end else if (gb_q < tgt_q) begin
          mem_re = 1'b1;
          mem_ra = gf_q[ADDR_W-1:0];
          wa_d   = gb_q[ADDR_W-1:0];
          gb_d   = gb_q + POS_W'(1);
          gf_d   = gf_q + POS_W'(1);
          pend_d = 1'b1;
        end else begin
          gf_d    = gf_q + span_q;
          state_d = ST_FINISH;
        end
      end
      ST_RDWAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          if (pop_valid_i) begin
            pop_o   = 1'b1;
            req_d   = pop_req_i;
            state_d = ST_EXEC;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gb_q        <= '0;
      gf_q        <= CAP_POS;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gb_q        <= gb_d;
      gf_q        <= gf_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    tgt_q      <= tgt_d;
    span_q     <= span_d;
    wa_q       <= wa_d;
    char_sel_q <= char_sel_d;
    stat_q     <= stat_d;
    if (load) begin
      out_status_q <= stat_q;
      out_cursor_q <= gb_q;
      out_len_q    <= len;
      out_char_q   <= char_sel_q ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_ra];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign cursor_o      = out_cursor_q;
  assign text_length_o = out_len_q;
  assign char_out_o    = out_char_q;

endmodule

@@ design/gap_buffer_text_store.sv @@
// Insert, backspace and unused codes pass from the request queue through
// the execute and finish steps to the result register; a read adds a
// read-wait step, and a cursor move or range delete a move step per byte
// carried across the gap, which reads and writes the memory at once. The
// back end takes a new request only when idle or in the finish step.
// Reset clears the cursor to 0, the gap end to the capacity and the queue.
// ----------------------------------------------------------------------------
// Gap buffer text store
// Byte text store with a cursor gap, split into a decoding front end, a
// short request queue and an executing back end with the text memory.
// ----------------------------------------------------------------------------
module gap_buffer_text_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gbts_pkg::OP_W-1:0]    operation_i,
  input  logic [gbts_pkg::CHAR_W-1:0]  char_in_i,
  input  logic [gbts_pkg::POS_W-1:0]   position_i,
  input  logic [gbts_pkg::POS_W-1:0]   end_position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gbts_pkg::STAT_W-1:0]  status_o,
  output logic [gbts_pkg::POS_W-1:0]   cursor_o,
  output logic [gbts_pkg::POS_W-1:0]   text_length_o,
  output logic [gbts_pkg::CHAR_W-1:0]  char_out_o
);

  logic           push_valid, push_ready;
  gbts_pkg::req_t push_req;
  logic           pop_valid, pop;
  gbts_pkg::req_t pop_req;

  gbts_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .char_in_i      (char_in_i),
    .position_i     (position_i),
    .end_position_i (end_position_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_req_o     (push_req)
  );

  gbts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_req_o    (pop_req)
  );

  gbts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_o         (pop),
    .pop_req_i     (pop_req),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .cursor_o      (cursor_o),
    .text_length_o (text_length_o),
    .char_out_o    (char_out_o)
  );

endmodule
